[rtl/bbrd_pkg.sv]
// shared types and constants of the bus bridge record decoder
// no dependencies

package bbrd_pkg;

  localparam int MSI_QUEUE_DEPTH_DEF = 16;

  localparam logic [31:0] PROBE_MAGIC = 32'h4e6f11ff;
  localparam logic [31:0] PROBE_REPLY = 32'h4e6f1644;

  localparam logic [1:0] KIND_REPLY = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [7:0] CFG_SDB_ADDRESS = 8'd0;
  localparam logic [7:0] CFG_MSI_FIRST   = 8'd1;
  localparam logic [7:0] CFG_MSI_LAST    = 8'd2;
  localparam logic [7:0] CFG_POLLED      = 8'd3;

  localparam logic [31:0] CSR_ERROR_HIST = 32'h00;
  localparam logic [31:0] CSR_SDB        = 32'h0c;
  localparam logic [31:0] CSR_MSI_CAP    = 32'h2c;
  localparam logic [31:0] CSR_MSI_FIRST  = 32'h34;
  localparam logic [31:0] CSR_MSI_LAST   = 32'h3c;
  localparam logic [31:0] CSR_MSI_ADDR   = 32'h40;
  localparam logic [31:0] CSR_MSI_DATA   = 32'h44;
  localparam logic [31:0] CSR_MSI_COUNT  = 32'h48;

  typedef struct packed {
    logic        func;
    logic [31:0] word;
    logic [31:0] msi_address;
    logic [31:0] msi_data;
  } bbrd_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] bus_address;
    logic [31:0] bus_data;
    logic [31:0] reply_word;
    logic        end_cycle;
    logic        error;
  } bbrd_result_t;

  typedef struct packed {
    logic        push;
    logic        pop;
    logic [63:0] entry;
  } bbrd_qctrl_t;

  typedef struct packed {
    logic        not_empty;
    logic        many;
    logic        full;
    logic [63:0] head_entry;
  } bbrd_qstat_t;

endpackage

[rtl/bus_bridge_record_decoder.sv]
// top level of the bus bridge record decoder: input and output beat registers
// depends on bbrd_pkg, bbrd_decoder, bbrd_msi_queue
//
//   channel  signals                          direction  beat
//   s        s_tvalid s_tready s_tdata s_tuser  in       stream word or msi event
//   m        m_tvalid m_tready m_tdata m_tuser  out      reply, bus write or bus read
//   cfg      cfg_valid cfg_ready cfg_index cfg_data in   register write
//
// one beat per cycle sustained while m_tready holds; an accepted beat is decoded while
// it sits in the input register and its result is registered in the output register
// msi queue head is prefetched from the ram, so a pop need not wait for a ram read
// reset is synchronous; no clearing pass, queue entries are only read once written
// a stalled output holds the decode stage and, once full, the input register

module bus_bridge_record_decoder #(
  parameter int MSI_QUEUE_DEPTH = bbrd_pkg::MSI_QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // word, msi_address, msi_data
  input  logic         s_tuser,   // func
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // bus_address, bus_data, reply_word, end_cycle, error, zeros
  output logic [1:0]   m_tuser,   // kind
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import bbrd_pkg::*;

  logic         in_valid;
  bbrd_item_t   in_item;
  logic         advance;
  logic         res_valid;
  bbrd_result_t res;
  bbrd_result_t out_res;
  bbrd_qctrl_t  qctrl;
  bbrd_qstat_t  qstat;

  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.func        <= s_tuser;
      in_item.word        <= s_tdata[31:0];
      in_item.msi_address <= s_tdata[63:32];
      in_item.msi_data    <= s_tdata[95:64];
    end
  end

  bbrd_decoder u_decoder (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .fire     (advance),
    .item     (in_item),
    .res_valid(res_valid),
    .res      (res),
    .qctrl    (qctrl),
    .qstat    (qstat)
  );

  bbrd_msi_queue #(
    .DEPTH(MSI_QUEUE_DEPTH)
  ) u_msi_queue (
    .clk (clk),
    .rst (rst),
    .ctrl(qctrl),
    .stat(qstat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tuser = out_res.kind;
  assign m_tdata = {6'd0, out_res.error, out_res.end_cycle, out_res.reply_word,
                    out_res.bus_data, out_res.bus_address};

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready) else $error("input register empty but not ready");

endmodule

[rtl/bbrd_ram.sv]
// generic single write port ram with registered read
// no dependencies

module bbrd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/bbrd_msi_queue.sv]
// msi event queue: ring buffer over a ram, head entry prefetched
// depends on bbrd_pkg and bbrd_ram

module bbrd_msi_queue #(
  parameter int DEPTH = bbrd_pkg::MSI_QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bbrd_pkg::bbrd_qctrl_t ctrl,
  output bbrd_pkg::bbrd_qstat_t stat
);
  import bbrd_pkg::*;

  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int SUM_W  = FILL_W + 1;

  logic [PTR_W-1:0]  head, head_next;
  logic [FILL_W-1:0] fill;
  logic [SUM_W-1:0]  slot_sum;
  logic [PTR_W-1:0]  slot;
  logic [63:0]       ram_q;
  logic              bypass;
  logic [63:0]       bypass_data;

  assign slot_sum = SUM_W'(head) + SUM_W'(fill);
  assign slot = (slot_sum >= SUM_W'(DEPTH)) ? PTR_W'(slot_sum - SUM_W'(DEPTH))
                                            : PTR_W'(slot_sum);

  always_comb begin
    head_next = head;
    if (ctrl.pop) begin
      head_next = (head == PTR_W'(DEPTH - 1)) ? '0 : head + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else begin
      head <= head_next;
      if (ctrl.push && !ctrl.pop) begin
        fill <= fill + 1'b1;
      end else if (ctrl.pop && !ctrl.push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  bbrd_ram #(
    .WIDTH(64),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ctrl.push),
    .waddr(slot),
    .wdata(ctrl.entry),
    .raddr(head_next),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    bypass      <= ctrl.push && (slot == head_next);
    bypass_data <= ctrl.entry;
  end

  assign stat.not_empty  = (fill != '0);
  assign stat.many       = (fill > FILL_W'(1));
  assign stat.full       = (fill == FILL_W'(DEPTH));
  assign stat.head_entry = bypass ? bypass_data : ram_q;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(DEPTH)) else $error("msi queue fill beyond depth");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.push && stat.full)) else $error("msi push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    ctrl.pop |-> stat.not_empty && !ctrl.push) else $error("bad msi pop");

endmodule

[rtl/bbrd_decoder.sv]
// record decode state machine, config registers and config-space window
// depends on bbrd_pkg

module bbrd_decoder (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [7:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic                  fire,
  input  bbrd_pkg::bbrd_item_t  item,
  output logic                  res_valid,
  output bbrd_pkg::bbrd_result_t res,
  output bbrd_pkg::bbrd_qctrl_t qctrl,
  input  bbrd_pkg::bbrd_qstat_t qstat
);
  import bbrd_pkg::*;

  localparam logic [2:0] MODE_IDLE      = 3'd0;
  localparam logic [2:0] MODE_PROBE_ID  = 3'd1;
  localparam logic [2:0] MODE_HEADER    = 3'd2;
  localparam logic [2:0] MODE_CFG_FIRST = 3'd3;
  localparam logic [2:0] MODE_CFG_REST  = 3'd4;
  localparam logic [2:0] MODE_BUS_FIRST = 3'd5;
  localparam logic [2:0] MODE_BUS_REST  = 3'd6;

  // flags: bca rca rff cyc wca wff from bit 5 down
  localparam int F_BCA = 5;
  localparam int F_RCA = 4;
  localparam int F_RFF = 3;
  localparam int F_CYC = 2;
  localparam int F_WCA = 1;
  localparam int F_WFF = 0;

  logic [31:0] sdb_address, msi_first, msi_last;
  logic        polled;

  logic [2:0]  mode, mode_next, mode_eff;
  logic [5:0]  flags, flags_next;
  logic [7:0]  writes_left, writes_left_next;
  logic [7:0]  reads_left, reads_left_next;
  logic [31:0] write_pointer, write_pointer_next;
  logic [31:0] pending_header, pending_header_next;
  logic [31:0] error_history, error_history_next;
  logic [31:0] held_address, held_address_next;
  logic [31:0] held_data, held_data_next;
  logic [1:0]  held_count, held_count_next;

  logic [31:0] w;
  logic        cyc;
  logic [5:0]  hdr_flags;
  logic [31:0] hdr_resp;
  logic        in_run;

  assign w   = item.word;
  assign cyc = flags[F_CYC];
  assign in_run = (mode >= MODE_CFG_FIRST) && (mode <= MODE_BUS_REST);
  assign mode_eff = (in_run && writes_left == 8'd0 && reads_left == 8'd0)
                    ? MODE_HEADER : mode;

  assign hdr_flags = {w[31], w[30], w[29], w[27], w[26], w[25]};
  assign hdr_resp  = {4'b0000, hdr_flags[F_CYC], hdr_flags[F_BCA], hdr_flags[F_RFF], 1'b0,
                      w[23:16], w[7:0], 8'h00};

  always_ff @(posedge clk) begin
    if (rst) begin
      sdb_address <= '0;
      msi_first   <= '0;
      msi_last    <= '0;
      polled      <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SDB_ADDRESS: sdb_address <= cfg_data;
        CFG_MSI_FIRST:   msi_first   <= cfg_data;
        CFG_MSI_LAST:    msi_last    <= cfg_data;
        CFG_POLLED:      polled      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mode_next           = mode;
    flags_next          = flags;
    writes_left_next    = writes_left;
    reads_left_next     = reads_left;
    write_pointer_next  = write_pointer;
    pending_header_next = pending_header;
    error_history_next  = error_history;
    held_address_next   = held_address;
    held_data_next      = held_data;
    held_count_next     = held_count;
    res_valid           = 1'b0;
    res                 = '0;
    res.kind            = KIND_REPLY;
    qctrl.push          = 1'b0;
    qctrl.pop           = 1'b0;
    qctrl.entry         = {item.msi_address & (msi_last - msi_first), item.msi_data};

    if (fire && item.func) begin
      qctrl.push = polled && !qstat.full;
    end else if (fire) begin
      res_valid = 1'b1;
      res.end_cycle = cyc;
      unique case (mode_eff)
        MODE_PROBE_ID: begin
          mode_next = MODE_HEADER;
          res.reply_word = w;
          res.end_cycle = 1'b0;
        end
        MODE_HEADER: begin
          flags_next = hdr_flags;
          writes_left_next = w[15:8];
          reads_left_next = w[7:0];
          res.end_cycle = w[27];
          res.reply_word = hdr_resp;
          if (w[15:8] != 8'd0) begin
            pending_header_next = hdr_resp;
            res.reply_word = '0;
            mode_next = hdr_flags[F_WCA] ? MODE_CFG_FIRST : MODE_BUS_FIRST;
          end else if (w[7:0] != 8'd0) begin
            mode_next = hdr_flags[F_RCA] ? MODE_CFG_FIRST : MODE_BUS_FIRST;
          end else begin
            mode_next = MODE_HEADER;
          end
        end
        MODE_CFG_FIRST: begin
          mode_next = MODE_CFG_REST;
          res.reply_word = (writes_left != 8'd0) ? 32'd0 : w;
        end
        MODE_CFG_REST: begin
          if (writes_left != 8'd0) begin
            writes_left_next = writes_left - 8'd1;
            if (writes_left == 8'd1) begin
              mode_next = (reads_left == 8'd0) ? MODE_HEADER : MODE_CFG_FIRST;
              res.reply_word = pending_header;
            end
          end else begin
            reads_left_next = reads_left - 8'd1;
            if (reads_left == 8'd1) begin
              mode_next = MODE_HEADER;
            end
            unique case (w)
              CSR_ERROR_HIST: begin
                res.reply_word = error_history;
              end
              CSR_SDB:       res.reply_word = sdb_address;
              CSR_MSI_CAP:   res.reply_word = 32'd1;
              CSR_MSI_FIRST: res.reply_word = msi_first;
              CSR_MSI_LAST:  res.reply_word = msi_last;
              CSR_MSI_ADDR: begin
                if (qstat.not_empty && polled) begin
                  qctrl.pop = 1'b1;
                  held_address_next = qstat.head_entry[63:32];
                  held_data_next = qstat.head_entry[31:0];
                  held_count_next = qstat.many ? 2'd3 : 2'd1;
                  res.reply_word = qstat.head_entry[63:32];
                end else begin
                  held_count_next = 2'd0;
                  res.reply_word = held_address;
                end
              end
              CSR_MSI_DATA:  res.reply_word = held_data;
              CSR_MSI_COUNT: res.reply_word = {30'd0, held_count};
              default:       res.error = 1'b1;
            endcase
          end
        end
        MODE_BUS_FIRST: begin
          mode_next = MODE_BUS_REST;
          if (writes_left != 8'd0) begin
            write_pointer_next = w;
          end else begin
            res.reply_word = w;
          end
        end
        MODE_BUS_REST: begin
          if (writes_left != 8'd0) begin
            writes_left_next = writes_left - 8'd1;
            res.kind = KIND_WRITE;
            res.bus_address = write_pointer;
            res.bus_data = w;
            if (!flags[F_WFF]) begin
              write_pointer_next = write_pointer + 32'd4;
            end
            if (writes_left == 8'd1) begin
              res.reply_word = pending_header;
              if (reads_left == 8'd0) begin
                mode_next = MODE_HEADER;
              end else begin
                mode_next = flags[F_RCA] ? MODE_CFG_FIRST : MODE_BUS_FIRST;
              end
            end
          end else begin
            reads_left_next = reads_left - 8'd1;
            res.kind = KIND_READ;
            res.bus_address = w;
            if (reads_left == 8'd1) begin
              mode_next = MODE_HEADER;
            end
          end
        end
        default: begin
          res.end_cycle = 1'b0;
          mode_next = MODE_IDLE;
          if (w == PROBE_MAGIC) begin
            mode_next = MODE_PROBE_ID;
            res.reply_word = PROBE_REPLY;
          end else begin
            res_valid = 1'b0;
          end
        end
      endcase
      if (res_valid) begin
        if (mode_eff == MODE_CFG_REST && writes_left == 8'd0 && w == CSR_ERROR_HIST) begin
          error_history_next = '0;
        end else begin
          error_history_next = {error_history[30:0], res.error};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      flags          <= '0;
      writes_left    <= '0;
      reads_left     <= '0;
      write_pointer  <= '0;
      pending_header <= '0;
      error_history  <= '0;
      held_address   <= '0;
      held_data      <= '0;
      held_count     <= '0;
    end else begin
      mode           <= mode_next;
      flags          <= flags_next;
      writes_left    <= writes_left_next;
      reads_left     <= reads_left_next;
      write_pointer  <= write_pointer_next;
      pending_header <= pending_header_next;
      error_history  <= error_history_next;
      held_address   <= held_address_next;
      held_data      <= held_data_next;
      held_count     <= held_count_next;
    end
  end

endmodule

[verif/bbrd_checker.sv]
`timescale 1ns / 100ps
// result checker of the bus bridge record decoder: watches the stream, result and
// register channels, decodes each accepted word itself and compares every result beat
// depends on bbrd_pkg

module bbrd_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [95:0]  s_tdata,   // word, msi_address, msi_data
  input  logic         s_tuser,   // func
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [103:0] m_tdata,   // bus_address, bus_data, reply_word, end_cycle, error, zeros
  input  logic [1:0]   m_tuser,   // kind
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           mismatches,
  output int           outstanding
);
  import bbrd_pkg::*;

  localparam int QUEUE_DEPTH = MSI_QUEUE_DEPTH_DEF;

  localparam logic [5:0] FL_BCA = 6'h20;
  localparam logic [5:0] FL_RCA = 6'h10;
  localparam logic [5:0] FL_RFF = 6'h08;
  localparam logic [5:0] FL_CYC = 6'h04;
  localparam logic [5:0] FL_WCA = 6'h02;
  localparam logic [5:0] FL_WFF = 6'h01;

  typedef enum logic [2:0] {
    DEC_IDLE,
    DEC_PROBE_ID,
    DEC_HEADER,
    DEC_CFG_FIRST,
    DEC_CFG_REST,
    DEC_BUS_FIRST,
    DEC_BUS_REST
  } dec_mode_e;

  logic [31:0]  sdb_addr, win_first, win_last;
  logic         polled;
  dec_mode_e    mode;
  logic [5:0]   flags;
  logic [7:0]   writes_left, reads_left;
  logic [31:0]  write_ptr, pend_header, err_history;
  logic [31:0]  held_addr, held_data;
  logic [1:0]   held_count;
  logic [63:0]  msi_events[$];
  bbrd_result_t pending_cmds[$];

  function automatic logic cyc_flag();
    return (flags & FL_CYC) != 6'h0;
  endfunction

  // every command shifts the error history, bus commands always with a zero
  function automatic void push_cmd(logic [1:0] kind, logic [31:0] adr, logic [31:0] dat,
                                   logic [31:0] rep, logic endc, logic err);
    bbrd_result_t r;
    r.kind        = kind;
    r.bus_address = adr;
    r.bus_data    = dat;
    r.reply_word  = rep;
    r.end_cycle   = endc;
    r.error       = err;
    pending_cmds.insert(pending_cmds.size(), r);
    err_history = {err_history[30:0], err};
  endfunction

  function automatic void send_reply(logic [31:0] v, logic err);
    push_cmd(KIND_REPLY, 32'h0, 32'h0, v, cyc_flag(), err);
  endfunction

  function automatic void decode_header(logic [31:0] w);
    logic [31:0] resp;
    flags       = {w[31], w[30], w[29], w[27], w[26], w[25]};
    writes_left = w[15:8];
    reads_left  = w[7:0];
    // byte enables echoed, read count becomes write count
    resp = {4'b0000, cyc_flag(), (flags & FL_BCA) != 6'h0, (flags & FL_RFF) != 6'h0, 1'b0,
            w[23:16], w[7:0], 8'h00};
    if (writes_left != 8'h0) begin
      pend_header = resp;
      resp = 32'h0;
      mode = ((flags & FL_WCA) != 6'h0) ? DEC_CFG_FIRST : DEC_BUS_FIRST;
    end else if (reads_left != 8'h0) begin
      mode = ((flags & FL_RCA) != 6'h0) ? DEC_CFG_FIRST : DEC_BUS_FIRST;
    end else begin
      mode = DEC_HEADER;
    end
    send_reply(resp, 1'b0);
  endfunction

  function automatic void read_csr(logic [31:0] adr);
    logic [31:0] v;
    logic        err;
    logic [63:0] ev;
    v   = 32'h0;
    err = 1'b0;
    case (adr)
      CSR_ERROR_HIST: begin
        v = err_history;
        err_history = 32'h0;
      end
      CSR_SDB:       v = sdb_addr;
      CSR_MSI_CAP:   v = 32'h1;
      CSR_MSI_FIRST: v = win_first;
      CSR_MSI_LAST:  v = win_last;
      CSR_MSI_ADDR: begin
        if (msi_events.size() > 0 && polled) begin
          ev = msi_events[0];
          msi_events.delete(0);
          held_addr  = ev[63:32];
          held_data  = ev[31:0];
          held_count = (msi_events.size() > 0) ? 2'd3 : 2'd1;
        end else begin
          held_count = 2'd0;
        end
        v = held_addr;
      end
      CSR_MSI_DATA:  v = held_data;
      CSR_MSI_COUNT: v = {30'h0, held_count};
      default:       err = 1'b1;
    endcase
    send_reply(v, err);
  endfunction

  function automatic void decode_word(bbrd_item_t it);
    logic [31:0] w;
    w = it.word;
    if (it.func) begin
      if (polled && msi_events.size() < QUEUE_DEPTH)
        msi_events.insert(msi_events.size(),
                          {it.msi_address & (win_last - win_first), it.msi_data});
      return;
    end
    if (mode >= DEC_CFG_FIRST && mode <= DEC_BUS_REST &&
        writes_left == 8'h0 && reads_left == 8'h0)
      mode = DEC_HEADER;
    case (mode)
      DEC_PROBE_ID: begin
        mode = DEC_HEADER;
        push_cmd(KIND_REPLY, 32'h0, 32'h0, w, 1'b0, 1'b0);
      end
      DEC_HEADER: decode_header(w);
      DEC_CFG_FIRST: begin
        mode = DEC_CFG_REST;
        send_reply((writes_left != 8'h0) ? 32'h0 : w, 1'b0);
      end
      DEC_CFG_REST: begin
        if (writes_left != 8'h0) begin
          writes_left = writes_left - 8'd1;
          if (writes_left == 8'h0)
            mode = (reads_left == 8'h0) ? DEC_HEADER : DEC_CFG_FIRST;
          send_reply((writes_left == 8'h0) ? pend_header : 32'h0, 1'b0);
        end else begin
          reads_left = reads_left - 8'd1;
          if (reads_left == 8'h0) mode = DEC_HEADER;
          read_csr(w);
        end
      end
      DEC_BUS_FIRST: begin
        mode = DEC_BUS_REST;
        if (writes_left != 8'h0) begin
          write_ptr = w;
          send_reply(32'h0, 1'b0);
        end else begin
          send_reply(w, 1'b0);
        end
      end
      DEC_BUS_REST: begin
        if (writes_left != 8'h0) begin
          writes_left = writes_left - 8'd1;
          push_cmd(KIND_WRITE, write_ptr, w, (writes_left == 8'h0) ? pend_header : 32'h0,
                   cyc_flag(), 1'b0);
          // fifo mode keeps the address
          if ((flags & FL_WFF) == 6'h0) write_ptr = write_ptr + 32'd4;
          if (writes_left == 8'h0) begin
            if (reads_left == 8'h0) mode = DEC_HEADER;
            else mode = ((flags & FL_RCA) != 6'h0) ? DEC_CFG_FIRST : DEC_BUS_FIRST;
          end
        end else begin
          reads_left = reads_left - 8'd1;
          push_cmd(KIND_READ, w, 32'h0, 32'h0, cyc_flag(), 1'b0);
          if (reads_left == 8'h0) mode = DEC_HEADER;
        end
      end
      default: begin
        mode = DEC_IDLE;
        if (w == PROBE_MAGIC) begin
          mode = DEC_PROBE_ID;
          push_cmd(KIND_REPLY, 32'h0, 32'h0, PROBE_REPLY, 1'b0, 1'b0);
        end
      end
    endcase
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %h got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    bbrd_item_t   item;
    bbrd_result_t want;
    if (rst) begin
      sdb_addr    = 32'h0;
      win_first   = 32'h0;
      win_last    = 32'h0;
      polled      = 1'b1;
      mode        = DEC_IDLE;
      flags       = 6'h0;
      writes_left = 8'h0;
      reads_left  = 8'h0;
      write_ptr   = 32'h0;
      pend_header = 32'h0;
      err_history = 32'h0;
      held_addr   = 32'h0;
      held_data   = 32'h0;
      held_count  = 2'd0;
      msi_events.delete();
      pending_cmds.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_cmds.size() == 0) begin
          $display("%0t ns: result beat with none expected, kind %h data %h",
                   $time, m_tuser, m_tdata);
          mismatches++;
        end else begin
          want = pending_cmds[0];
          pending_cmds.delete(0);
          check_field("kind", want.kind, m_tuser);
          check_field("bus_address", want.bus_address, m_tdata[31:0]);
          check_field("bus_data", want.bus_data, m_tdata[63:32]);
          check_field("reply_word", want.reply_word, m_tdata[95:64]);
          check_field("end_cycle", want.end_cycle, m_tdata[96]);
          check_field("error", want.error, m_tdata[97]);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SDB_ADDRESS: sdb_addr  = cfg_data;
          CFG_MSI_FIRST:   win_first = cfg_data;
          CFG_MSI_LAST:    win_last  = cfg_data;
          CFG_POLLED:      polled    = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        item.func        = s_tuser;
        item.word        = s_tdata[31:0];
        item.msi_address = s_tdata[63:32];
        item.msi_data    = s_tdata[95:64];
        decode_word(item);
      end
    end
    outstanding <= pending_cmds.size();
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// testbench top of the bus bridge record decoder: clock, reset, register writes,
// stream and msi stimulus with random gaps and back-pressure, and the verdict
// depends on bbrd_pkg, bus_bridge_record_decoder and bbrd_checker

module tb_top;
  import bbrd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_WORDS = 125;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [95:0]  s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [7:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  logic         steady = 1'b0;
  logic         big_record = 1'b0;
  int           mismatches;
  int           outstanding;
  logic [31:0]  record_words[$];

  bus_bridge_record_decoder DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bbrd_checker u_decode_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= !rst && (steady || $urandom_range(99) >= 36);
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_beat(logic func, logic [31:0] word, logic [31:0] addr,
                           logic [31:0] data);
    if (!steady) begin
      while ($urandom_range(99) < 36) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {data, addr, word};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_word(logic [31:0] word);
    send_beat(1'b0, word, $urandom, $urandom);
  endtask

  task automatic send_msi(logic [31:0] addr, logic [31:0] data);
    send_beat(1'b1, $urandom, addr, data);
  endtask

  // hold off until every result is back, then let trailing msi beats settle
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_regs(logic [31:0] sdb, logic [31:0] first, logic [31:0] last,
                            logic pol);
    logic [7:0]  idx[4];
    logic [31:0] vals[4];
    idx  = '{CFG_SDB_ADDRESS, CFG_MSI_FIRST, CFG_MSI_LAST, CFG_POLLED};
    vals = '{sdb, first, last, {31'h0, pol}};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_offset();
    logic [31:0] csr_map[8];
    int          sel;
    csr_map = '{CSR_ERROR_HIST, CSR_SDB, CSR_MSI_CAP, CSR_MSI_FIRST, CSR_MSI_LAST,
                CSR_MSI_ADDR, CSR_MSI_DATA, CSR_MSI_COUNT};
    sel = $urandom_range(11);
    if (sel < 8) return csr_map[sel];
    if (sel < 10) return CSR_MSI_ADDR;
    if (sel == 10) return $urandom_range(255);
    return $urandom;
  endfunction

  // queues the words that follow a header and returns the header
  function automatic logic [31:0] plan_record(int wc, int rc);
    logic [31:0] hdr;
    logic        to_csr;
    hdr       = $urandom;
    hdr[15:8] = wc[7:0];
    hdr[7:0]  = rc[7:0];
    to_csr    = (wc > 0 && hdr[26]) || hdr[30];
    if (wc > 0) begin
      if ($urandom_range(3) == 0)
        record_words.insert(record_words.size(), 32'hffff_fff0 + $urandom_range(15));
      else record_words.insert(record_words.size(), $urandom);
      repeat (wc) record_words.insert(record_words.size(), $urandom);
    end
    if (rc > 0) begin
      record_words.insert(record_words.size(), $urandom);
      repeat (rc) record_words.insert(record_words.size(), to_csr ? pick_offset() : $urandom);
    end
    return hdr;
  endfunction

  task automatic next_beat(int msi_pct);
    logic [31:0] w;
    if ($urandom_range(99) < msi_pct) begin
      if ($urandom_range(3) == 0) send_msi(32'hffff_ffff, $urandom);
      else send_msi($urandom, $urandom);
    end
    if (record_words.size() == 0) begin
      if (big_record) begin
        w = plan_record(255, 255);
        big_record = 1'b0;
      end else begin
        w = plan_record($urandom_range(4), $urandom_range(4));
      end
    end else if ($urandom_range(99) < 3) begin
      // broken record: a magic or a header lands where data belongs
      record_words.delete(0);
      w = ($urandom_range(1) == 0) ? PROBE_MAGIC
                                   : {16'($urandom_range(16'hffff)), 16'h0101};
    end else begin
      w = record_words[0];
      record_words.delete(0);
    end
    send_word(w);
  endtask

  initial begin : stimulus
    int msi_pct;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    write_regs($urandom, 32'h0, 32'hffff_ffff, 1'b1);

    // words ignored while idle and msi events queued, then probe and echo
    send_word(32'h0000_0000);
    send_word(32'hffff_ffff);
    send_msi(32'hffff_ffff, 32'hffff_ffff);
    send_msi(32'h0000_0000, 32'h0000_0000);
    send_word(PROBE_MAGIC);
    send_word(32'hffff_ffff);
    // empty record
    send_word(32'hffff_0000);
    // config write then config reads
    send_word(32'h4c0f_0104);
    send_word(32'h0000_0000);
    send_word(32'hffff_ffff);
    send_word(32'h8000_0000);
    send_word(CSR_MSI_ADDR);
    send_word(CSR_MSI_COUNT);
    send_word(32'h0000_0099);
    send_word(CSR_ERROR_HIST);
    // bus writes wrapping the address, then a bus read
    send_word(32'ha8ff_0201);
    send_word(32'hffff_fffc);
    send_word(32'h0000_0000);
    send_word(32'hffff_ffff);
    send_word(32'h0000_0000);
    send_word(32'hffff_ffff);

    for (int phase = 0; phase < 5; phase++) begin
      drain();
      case (phase)
        0:       write_regs(32'hffff_ffff, 32'hffff_ffff, 32'h0, 1'b1);
        1:       write_regs(32'h0, 32'h0, 32'h0, 1'b1);
        2:       write_regs($urandom, $urandom, $urandom, 1'b0);
        3:       write_regs($urandom, 32'h1000, 32'h1fff, 1'b1);
        default: write_regs($urandom, $urandom, $urandom, 1'b1);
      endcase
      steady <= (phase == 3);
      big_record = (phase == 3);
      msi_pct = (phase == 1) ? 35 : 12;
      for (int n = 0; n < PHASE_WORDS; n++) next_beat(msi_pct);
    end
    drain();

    if (mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

[files.f]
rtl/bbrd_pkg.sv
rtl/bbrd_ram.sv
rtl/bbrd_msi_queue.sv
rtl/bbrd_decoder.sv
rtl/bus_bridge_record_decoder.sv
verif/bbrd_checker.sv
verif/tb_top.sv
